// ----- hdl/consistent_hash_ring_lookup_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the consistent hash ring lookup unit
// Shared forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_LOOKUP_UNIT_ASSERT_SVH
`define CONSISTENT_HASH_RING_LOOKUP_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CHRL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chrl: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CHRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chrl: next-cycle check failed");

`endif

// ----- hdl/chrl_pkg.sv -----
// ----------------------------------------------------------------------------
// chrl_pkg
// Types, codes and key mixing steps shared by the ring lookup unit.
// ----------------------------------------------------------------------------
package chrl_pkg;

   localparam int unsigned SECTION_W   = 16;
   localparam int unsigned SPLIT_W     = 10;
   localparam int unsigned HASH_W      = 32;
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned KEY_LEN_W   = 8;
   localparam int unsigned QUEUE_DEPTH = 2;   // power of two

   localparam logic [KEY_LEN_W-1:0] KEY_LEN_FULL = 8'd8;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_MIN  = 8'd5;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX  = 8'd7;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_KEY  = 2'd1,
      CMD_MIX  = 2'd2,
      CMD_RAW  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_KEY = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_SKIP    = 2'd3
   } status_type;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_SEARCH,
      OP_BAD_KEY
   } op_type;

   typedef enum logic [1:0] {
      MIX_A,
      MIX_B,
      MIX_C
   } mix_step_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_MIX,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_FIRST,
      BE_LAST,
      BE_PROBE,
      BE_NODE
   } be_state_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [KEY_W-1:0]       key_bytes;
      logic [KEY_LEN_W-1:0]   key_len;
      logic [HASH_W-1:0]      lookup_value;
      logic [HASH_W-1:0]      entry_hash;
      logic [SECTION_W-1:0]   entry_node;
   } req_type;

   typedef struct packed {
      logic [SECTION_W-1:0]   section;
      logic [SPLIT_W-1:0]     split_index;
      status_type             status;
   } rsp_type;

   // value carries the search word, or the ring hash for a load
   typedef struct packed {
      op_type                 op;
      logic [HASH_W-1:0]      value;
      logic [SECTION_W-1:0]   node;
   } qent_type;

   // integer mix, split in three add/xor-shift steps
   function automatic logic [HASH_W-1:0] mix_a(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + ~(v << 15);
      return t ^ (t >> 10);
   endfunction

   function automatic logic [HASH_W-1:0] mix_b(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + (v << 3);
      return t ^ (t >> 6);
   endfunction

   function automatic logic [HASH_W-1:0] mix_c(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + ~(v << 11);
      return t ^ (t >> 16);
   endfunction

endpackage

// ----- hdl/chrl_front.sv -----
// ----------------------------------------------------------------------------
// chrl_front
// Takes a request, classifies it, folds or mixes the key, queues the work.
// ----------------------------------------------------------------------------
module chrl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  chrl_pkg::req_type req_data,
   output logic              q_push,
   input  logic              q_full,
   output chrl_pkg::qent_type q_wdata
);
   import chrl_pkg::*;

   fe_state_type state_ff, state_in;
   mix_step_type step_ff, step_in;
   qent_type     ent_ff, ent_in;

   // state and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      ent_ff  <= ent_in;
   end

   // classify, mix, hand over
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ent_in   = ent_ff;
      q_push   = 1'b0;
      q_wdata  = ent_ff;
      req_full = (state_ff != FE_IDLE);

      unique case (state_ff)
         FE_IDLE: begin
            if (req_push) begin
               ent_in.op    = OP_SEARCH;
               ent_in.value = req_data.lookup_value;
               ent_in.node  = req_data.entry_node;
               step_in      = MIX_A;
               state_in     = FE_PUSH;
               unique case (req_data.cmd)
                  CMD_LOAD: begin
                     ent_in.op    = OP_LOAD;
                     ent_in.value = req_data.entry_hash;
                  end
                  CMD_KEY: begin
                     if (req_data.key_len == KEY_LEN_FULL) begin
                        ent_in.value = req_data.key_bytes[HASH_W-1:0] ^
                                       req_data.key_bytes[KEY_W-1:HASH_W];
                     end else if (req_data.key_len >= KEY_LEN_MIN &&
                                  req_data.key_len <= KEY_LEN_MAX) begin
                        ent_in.value = req_data.key_bytes[HASH_W-1:0];
                        state_in     = FE_MIX;
                     end else begin
                        ent_in.op = OP_BAD_KEY;
                     end
                  end
                  CMD_MIX: begin
                     state_in = FE_MIX;
                  end
                  CMD_RAW: begin
                     state_in = FE_PUSH;
                  end
                  default: begin
                     ent_in.op = OP_BAD_KEY;
                  end
               endcase
            end
         end

         // one add/xor-shift pair per cycle
         FE_MIX: begin
            unique case (step_ff)
               MIX_A: begin
                  ent_in.value = mix_a(ent_ff.value);
                  step_in      = MIX_B;
               end
               MIX_B: begin
                  ent_in.value = mix_b(ent_ff.value);
                  step_in      = MIX_C;
               end
               MIX_C: begin
                  ent_in.value = mix_c(ent_ff.value);
                  state_in     = FE_PUSH;
               end
               default: begin
                  step_in = MIX_A;
               end
            endcase
         end

         FE_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FE_IDLE;
            end
         end

         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/chrl_queue.sv -----
// ----------------------------------------------------------------------------
// chrl_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module chrl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   output logic               q_full,
   input  chrl_pkg::qent_type q_wdata,
   input  logic               q_pop,
   output logic               q_empty,
   output chrl_pkg::qent_type q_rdata
);
   import chrl_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   qent_type           slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_rdata = slots_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

// ----- hdl/chrl_back.sv -----
// ----------------------------------------------------------------------------
// chrl_back
// Ring table memory, loads, lower-bound search and the result register.
// ----------------------------------------------------------------------------
module chrl_back #(
   parameter int unsigned RING_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [chrl_pkg::SECTION_W-1:0] active_sections,
   input  logic                           q_empty,
   input  chrl_pkg::qent_type             q_rdata,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output chrl_pkg::rsp_type              rsp_data
);
   import chrl_pkg::*;

   localparam int unsigned IDX_W = $clog2(RING_DEPTH);
   localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

   be_state_type         state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [HASH_W-1:0]    value_ff, value_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     span_ff, span_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [HASH_W-1:0]    hash_mem_ff [RING_DEPTH];
   logic [SECTION_W-1:0] node_mem_ff [RING_DEPTH];
   logic [HASH_W-1:0]    rd_hash_ff;
   logic [SECTION_W-1:0] rd_node_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;

   logic                 out_free;
   logic [CNT_W-1:0]     half;
   logic [CNT_W-1:0]     next_first;
   logic [CNT_W-1:0]     next_span;
   logic [IDX_W-1:0]     found;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_pop;

   // ring memories, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hash_mem_ff[count_ff[IDX_W-1:0]] <= q_rdata.value;
         node_mem_ff[count_ff[IDX_W-1:0]] <= q_rdata.node;
      end
      rd_hash_ff <= hash_mem_ff[rd_addr];
      rd_node_ff <= node_mem_ff[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // search and result registers
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      first_ff <= first_in;
      span_ff  <= span_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   // one halving step per cycle on the previous read
   always_comb begin
      half = span_ff >> 1;
      if (rd_hash_ff < value_ff) begin
         next_first = first_ff + half + 1'b1;
         next_span  = span_ff - half - 1'b1;
      end else begin
         next_first = first_ff;
         next_span  = half;
      end
      if (next_first >= count_ff) begin
         found = '0;
      end else begin
         found = next_first[IDX_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      value_in     = value_ff;
      first_in     = first_ff;
      span_in      = span_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = idx_ff;

      unique case (state_ff)
         BE_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               unique case (q_rdata.op)
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (q_rdata.node >= active_sections ||
                         count_ff == CNT_W'(RING_DEPTH)) begin
                        rsp_in = '{section: '0, split_index: '0, status: ST_SKIP};
                     end else begin
                        wr_en    = 1'b1;
                        rsp_in   = '{section: q_rdata.node,
                                     split_index: SPLIT_W'(count_ff),
                                     status: ST_OK};
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{section: '0, split_index: '0, status: ST_EMPTY};
                     end else begin
                        value_in = q_rdata.value;
                        rd_addr  = '0;
                        state_in = BE_FIRST;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{section: '0, split_index: '0, status: ST_BAD_KEY};
                  end
               endcase
            end
         end

         // at or below the first point: wrap to entry 0
         BE_FIRST: begin
            if (value_ff <= rd_hash_ff) begin
               idx_in   = '0;
               rd_addr  = '0;
               state_in = BE_NODE;
            end else begin
               rd_addr  = IDX_W'(count_ff - 1'b1);
               state_in = BE_LAST;
            end
         end

         // above the last point: wrap, else start halving
         BE_LAST: begin
            if (value_ff > rd_hash_ff) begin
               idx_in   = '0;
               rd_addr  = '0;
               state_in = BE_NODE;
            end else begin
               first_in = '0;
               span_in  = count_ff;
               rd_addr  = IDX_W'(count_ff >> 1);
               state_in = BE_PROBE;
            end
         end

         BE_PROBE: begin
            first_in = next_first;
            span_in  = next_span;
            if (next_span != '0) begin
               rd_addr = IDX_W'(next_first + (next_span >> 1));
            end else begin
               idx_in   = found;
               rd_addr  = found;
               state_in = BE_NODE;
            end
         end

         // slot was freed when the request was taken
         BE_NODE: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{section: rd_node_ff,
                             split_index: SPLIT_W'(idx_ff),
                             status: ST_OK};
            state_in     = BE_IDLE;
         end

         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/consistent_hash_ring_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit
// Consistent-hash ring table with key folding and lower-bound lookup.
// ----------------------------------------------------------------------------
// Ring points are loaded with cmd 0 in ascending hash order; a point is kept
// only if its node is below csr active_sections when it is loaded, and at
// most RING_DEPTH points are kept. Lookups (cmd 1 key, cmd 2 mixed word,
// cmd 3 raw word) give the section and table index of the first point at or
// above the value, wrapping to entry 0. Every request gives exactly one
// response. A request passes the front (through the integer mix for cmd 2
// and short keys), the queue and the back; a lookup reads the first and the
// last point, then halves the span, one halving step per read of the ring
// memory, which has a registered read. Requests are taken one at a time in
// the front; the back and the response register overlap with it.
// The ring memory is not cleared; only loaded entries are ever read.
module consistent_hash_ring_lookup_unit #(
   parameter int unsigned RING_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  chrl_pkg::req_type              req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output chrl_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [chrl_pkg::SECTION_W-1:0] csr_wdata
);
   import chrl_pkg::*;

   logic [SECTION_W-1:0] active_sections_ff;
   logic                 q_push, q_full, q_pop, q_empty;
   qent_type             q_wdata, q_rdata;

   // active section count register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_sections_ff <= SECTION_W'(1);
      end else if (csr_we) begin
         active_sections_ff <= csr_wdata;
      end
   end

   chrl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_wdata  (q_wdata)
   );

   chrl_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_wdata (q_wdata),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_rdata (q_rdata)
   );

   chrl_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .active_sections (active_sections_ff),
      .q_empty         (q_empty),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data)
   );

endmodule

// ----- hdl/chrl_checker.sv -----
// ----------------------------------------------------------------------------
// chrl_checker
// Port-level checks on the ring lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "consistent_hash_ring_lookup_unit_assert.svh"

module chrl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input chrl_pkg::rsp_type rsp_data
);
   import chrl_pkg::*;

   logic [2:0] outstanding_ff, outstanding_in;
   logic       accept, deliver;

   assign accept  = req_push && !req_full;
   assign deliver = rsp_pop && !rsp_empty;

   // requests taken but not yet answered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (accept && !deliver) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (deliver && !accept) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `CHRL_ASSERT_IMPL(a_empty_after_reset, clock, reset, $past(reset), rsp_empty)
   `CHRL_ASSERT_IMPL(a_rsp_has_request, clock, reset, !rsp_empty, outstanding_ff != 3'd0)
   `CHRL_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_full)
   `CHRL_ASSERT_NEXT(a_rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

endmodule

bind consistent_hash_ring_lookup_unit chrl_checker u_chrl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
